// File: design/timestamp_ordered_request_queue_macros.svh
// Assertion macros for the timestamp ordered request queue.
// Used by the top level only; needs no other file.
`ifndef TIMESTAMP_ORDERED_REQUEST_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_REQUEST_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TORQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TORQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/torq_pkg.sv
// Shared types and constants of the timestamp ordered request queue.
// No dependencies; compiled before every other file.
`timescale 1ns / 1ps

package torq_pkg;

  localparam int MODE_W   = 2;
  localparam int PID_W    = 8;
  localparam int TS_W     = 32;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 4;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NONE        = 4'd0;
  localparam cmd_t CMD_LOAD        = 4'd1;
  localparam cmd_t CMD_SET_FULL    = 4'd2;
  localparam cmd_t CMD_SET_MISS    = 4'd3;
  localparam cmd_t CMD_INS_BEGIN   = 4'd4;
  localparam cmd_t CMD_INS_SHIFT   = 4'd5;
  localparam cmd_t CMD_INS_PUT     = 4'd6;
  localparam cmd_t CMD_REM_BEGIN   = 4'd7;
  localparam cmd_t CMD_REM_NEXT    = 4'd8;
  localparam cmd_t CMD_REM_GRAB    = 4'd9;
  localparam cmd_t CMD_REM_MOVE    = 4'd10;
  localparam cmd_t CMD_REM_DROP    = 4'd11;
  localparam cmd_t CMD_SCAN_BEGIN  = 4'd12;
  localparam cmd_t CMD_SCAN_STEP   = 4'd13;
  localparam cmd_t CMD_PUBLISH     = 4'd14;

  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic full;
    logic cnt_zero;
    logic move;
    logic match;
    logic idx_one;
    logic idx_last;
    logic idx_next_last;
    logic out_free;
  } status_t;

endpackage

// File: design/torq_in_if.sv
// Request channel: valid/ready handshake carrying one queue operation.
// Depends on torq_pkg for field widths.
`timescale 1ns / 1ps

interface torq_in_if;
  logic                          valid;
  logic                          ready;
  logic [torq_pkg::MODE_W-1:0]   mode;
  logic [torq_pkg::PID_W-1:0]    process_id;
  logic [torq_pkg::TS_W-1:0]     timestamp;
  logic                          is_boss;

  modport source (output valid, mode, process_id, timestamp, is_boss, input ready);
  modport sink   (input valid, mode, process_id, timestamp, is_boss, output ready);
endinterface

// File: design/torq_out_if.sv
// Result channel: valid/ready handshake carrying one operation result.
// Depends on torq_pkg for field widths.
`timescale 1ns / 1ps

interface torq_out_if;
  logic                            valid;
  logic                            ready;
  logic [torq_pkg::STATUS_W-1:0]   status;
  logic [torq_pkg::COUNT_W-1:0]    entry_count;
  logic                            head_valid;
  logic [torq_pkg::PID_W-1:0]      head_id;
  logic                            id_found;
  logic [torq_pkg::POS_W-1:0]      id_position;

  modport source (output valid, status, entry_count, head_valid, head_id, id_found,
                  id_position, input ready);
  modport sink   (input valid, status, entry_count, head_valid, head_id, id_found,
                  id_position, output ready);
endinterface

// File: design/torq_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the capacity limit.
// Depends on torq_pkg for the field width.
`timescale 1ns / 1ps

interface torq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [torq_pkg::CAP_W-1:0]   capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// File: design/torq_ctrl.sv
// Controller of the request queue: sequences insert, remove and scan passes.
// Depends on torq_pkg for command codes and the status struct.
`timescale 1ns / 1ps

module torq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  torq_pkg::status_t status,
  output torq_pkg::cmd_t    cmd
);
  import torq_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISP       = 4'd1;
  localparam logic [3:0] S_INS_CMP    = 4'd2;
  localparam logic [3:0] S_INS_PUT    = 4'd3;
  localparam logic [3:0] S_REM_CMP    = 4'd4;
  localparam logic [3:0] S_REM_SHIFT  = 4'd5;
  localparam logic [3:0] S_REM_DONE   = 4'd6;
  localparam logic [3:0] S_SCAN_START = 4'd7;
  localparam logic [3:0] S_SCAN_CMP   = 4'd8;
  localparam logic [3:0] S_OUT        = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (status.is_insert) begin
          if (status.full) begin
            cmd       = CMD_SET_FULL;
            state_nxt = S_SCAN_START;
          end else begin
            cmd       = CMD_INS_BEGIN;
            state_nxt = status.cnt_zero ? S_INS_PUT : S_INS_CMP;
          end
        end else if (status.is_remove) begin
          if (status.cnt_zero) begin
            cmd       = CMD_SET_MISS;
            state_nxt = S_SCAN_START;
          end else begin
            cmd       = CMD_REM_BEGIN;
            state_nxt = S_REM_CMP;
          end
        end else begin
          state_nxt = S_SCAN_START;
        end
      end
      S_INS_CMP: begin
        // walk the hole towards the head while the new entry outranks its neighbour
        if (status.move) begin
          cmd       = CMD_INS_SHIFT;
          state_nxt = status.idx_one ? S_INS_PUT : S_INS_CMP;
        end else begin
          cmd       = CMD_INS_PUT;
          state_nxt = S_SCAN_START;
        end
      end
      S_INS_PUT: begin
        cmd       = CMD_INS_PUT;
        state_nxt = S_SCAN_START;
      end
      S_REM_CMP: begin
        if (status.match) begin
          if (status.idx_last) begin
            cmd       = CMD_REM_DROP;
            state_nxt = S_SCAN_START;
          end else begin
            cmd       = CMD_REM_GRAB;
            state_nxt = S_REM_SHIFT;
          end
        end else if (status.idx_last) begin
          cmd       = CMD_SET_MISS;
          state_nxt = S_SCAN_START;
        end else begin
          cmd       = CMD_REM_NEXT;
        end
      end
      S_REM_SHIFT: begin
        // close the gap one entry a cycle
        cmd       = CMD_REM_MOVE;
        state_nxt = status.idx_next_last ? S_REM_DONE : S_REM_SHIFT;
      end
      S_REM_DONE: begin
        cmd       = CMD_REM_DROP;
        state_nxt = S_SCAN_START;
      end
      S_SCAN_START: begin
        if (status.cnt_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd       = CMD_SCAN_BEGIN;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd       = CMD_SCAN_STEP;
        state_nxt = status.idx_last ? S_OUT : S_SCAN_CMP;
      end
      S_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd       = CMD_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/torq_datapath.sv
// Datapath of the request queue: entry memories, count, capacity and result register.
// Depends on torq_pkg; driven by command codes from torq_ctrl.
`timescale 1ns / 1ps

module torq_datapath #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  torq_pkg::cmd_t                  cmd,
  output torq_pkg::status_t               status,
  input  logic [torq_pkg::MODE_W-1:0]     in_mode,
  input  logic [torq_pkg::PID_W-1:0]      in_process_id,
  input  logic [torq_pkg::TS_W-1:0]       in_timestamp,
  input  logic                            in_is_boss,
  input  logic                            cfg_valid,
  input  logic [torq_pkg::CAP_W-1:0]      cfg_capacity_limit,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [torq_pkg::STATUS_W-1:0]   out_status,
  output logic [torq_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                            out_head_valid,
  output logic [torq_pkg::PID_W-1:0]      out_head_id,
  output logic                            out_id_found,
  output logic [torq_pkg::POS_W-1:0]      out_id_position
);
  import torq_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [ID_BITS-1:0] mem_id_r [DEPTH];
  logic [TS_W-1:0]    mem_ts_r [DEPTH];
  logic               mem_pr_r [DEPTH];

  logic [ID_BITS-1:0] rd_id_r;
  logic [TS_W-1:0]    rd_ts_r;
  logic               rd_pr_r;

  logic [MODE_W-1:0]  op_mode_r;
  logic [ID_BITS-1:0] op_id_r;
  logic [TS_W-1:0]    op_ts_r;
  logic               op_boss_r;

  logic [CW-1:0]       cnt_r;
  logic [IW-1:0]       idx_r;
  logic [CAP_W-1:0]    cap_r;
  logic [ID_BITS-1:0]  head_r;
  logic                found_r;
  logic [IW-1:0]       pos_r;
  logic [STATUS_W-1:0] st_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_head_valid_r;
  logic [PID_W-1:0]    out_head_id_r;
  logic                out_found_r;
  logic [POS_W-1:0]    out_pos_r;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [ID_BITS-1:0] wr_id;
  logic [TS_W-1:0]    wr_ts;
  logic               wr_pr;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_id   = rd_id_r;
    wr_ts   = rd_ts_r;
    wr_pr   = rd_pr_r;
    case (cmd)
      CMD_INS_BEGIN: begin
        rd_en   = 1'b1;
        rd_addr = IW'(cnt_r - CW'(1));
      end
      CMD_INS_SHIFT: begin
        rd_en   = 1'b1;
        rd_addr = IW'(idx_r - IW'(2));
        wr_en   = 1'b1;
      end
      CMD_INS_PUT: begin
        wr_en = 1'b1;
        wr_id = op_id_r;
        wr_ts = op_ts_r;
        wr_pr = op_boss_r;
      end
      CMD_REM_BEGIN, CMD_SCAN_BEGIN: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      CMD_REM_NEXT, CMD_REM_GRAB, CMD_SCAN_STEP: begin
        rd_en   = 1'b1;
        rd_addr = IW'(idx_r + IW'(1));
      end
      CMD_REM_MOVE: begin
        rd_en   = 1'b1;
        rd_addr = IW'(idx_r + IW'(2));
        wr_en   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id_r[wr_addr] <= wr_id;
      mem_ts_r[wr_addr] <= wr_ts;
      mem_pr_r[wr_addr] <= wr_pr;
    end
    if (rd_en) begin
      rd_id_r <= mem_id_r[rd_addr];
      rd_ts_r <= mem_ts_r[rd_addr];
      rd_pr_r <= mem_pr_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_capacity_limit;
      end
      if (cmd == CMD_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_INS_BEGIN: cnt_r <= cnt_r + CW'(1);
        CMD_REM_DROP:  cnt_r <= cnt_r - CW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_mode_r <= in_mode;
        op_id_r   <= ID_BITS'(in_process_id);
        op_ts_r   <= in_timestamp;
        op_boss_r <= in_is_boss;
        found_r   <= 1'b0;
        pos_r     <= '0;
        head_r    <= '0;
        st_r      <= ST_DONE;
      end
      CMD_SET_FULL:  st_r  <= ST_FULL;
      CMD_SET_MISS:  st_r  <= ST_MISSING;
      CMD_INS_BEGIN: idx_r <= IW'(cnt_r);
      CMD_INS_SHIFT: idx_r <= idx_r - IW'(1);
      CMD_REM_BEGIN, CMD_SCAN_BEGIN: idx_r <= '0;
      CMD_REM_NEXT, CMD_REM_MOVE:    idx_r <= idx_r + IW'(1);
      CMD_SCAN_STEP: begin
        if (idx_r == '0) begin
          head_r <= rd_id_r;
        end
        // keep the last match, so duplicates report the highest index
        if (rd_id_r == op_id_r) begin
          found_r <= 1'b1;
          pos_r   <= idx_r;
        end
        idx_r <= idx_r + IW'(1);
      end
      CMD_PUBLISH: begin
        out_status_r     <= st_r;
        out_count_r      <= COUNT_W'(cnt_r);
        out_head_valid_r <= (cnt_r != '0);
        out_head_id_r    <= PID_W'(head_r);
        out_found_r      <= found_r;
        out_pos_r        <= POS_W'(pos_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.is_insert     = (op_mode_r == MODE_INSERT);
    status.is_remove     = (op_mode_r == MODE_REMOVE);
    status.full          = (CMPW'(cnt_r) >= CMPW'(cap_r)) || (cnt_r >= CW'(DEPTH));
    status.cnt_zero      = (cnt_r == '0);
    status.move          = !rd_pr_r &&
                           (op_boss_r || (op_ts_r < rd_ts_r) ||
                            ((op_ts_r == rd_ts_r) && (op_id_r < rd_id_r)));
    status.match         = (rd_id_r == op_id_r);
    status.idx_one       = (idx_r == IW'(1));
    status.idx_last      = (CW'(idx_r) == cnt_r - CW'(1));
    status.idx_next_last = (CW'(idx_r) + CW'(1) == cnt_r - CW'(1));
    status.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_head_valid  = out_head_valid_r;
  assign out_head_id     = out_head_id_r;
  assign out_id_found    = out_found_r;
  assign out_id_position = out_pos_r;

endmodule

// File: design/timestamp_ordered_request_queue.sv
// Each operation ends with a scan of the held entries, after the search and shift of a remove or
// the shift of an insert; every step of the shift and the scans is one memory access.
// One item in flight at a time; the next is taken once the result of the last sits in the output
// register, even if not yet taken.
// Reset (synchronous, active low) empties the queue and sets the capacity limit to 16.
// Entry memory contents are not cleared; entries past the count may be read but are never used.
`timescale 1ns / 1ps
`include "timestamp_ordered_request_queue_macros.svh"

module timestamp_ordered_request_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  torq_in_if.sink    in_ch,
  torq_out_if.source out_ch,
  torq_cfg_if.sink   cfg_ch
);
  import torq_pkg::*;

  cmd_t    ctrl_cmd;
  status_t dp_status;

  assign cfg_ch.ready = 1'b1;

  torq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  torq_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (ctrl_cmd),
    .status             (dp_status),
    .in_mode            (in_ch.mode),
    .in_process_id      (in_ch.process_id),
    .in_timestamp       (in_ch.timestamp),
    .in_is_boss         (in_ch.is_boss),
    .cfg_valid          (cfg_ch.valid),
    .cfg_capacity_limit (cfg_ch.capacity_limit),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_entry_count    (out_ch.entry_count),
    .out_head_valid     (out_ch.head_valid),
    .out_head_id        (out_ch.head_id),
    .out_id_found       (out_ch.id_found),
    .out_id_position    (out_ch.id_position)
  );

  `TORQ_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready,
                   !in_ch.ready, "request beat taken while busy")
  `TORQ_ASSERT_IMP(a_miss_not_found, clk, rst_n, out_ch.valid && (out_ch.status == ST_MISSING),
                   !out_ch.id_found, "remove miss reports id present")
  `TORQ_ASSERT_IMP(a_pos_zero, clk, rst_n, out_ch.valid && !out_ch.id_found,
                   out_ch.id_position == '0, "position set without a match")

endmodule
